// ----- hw/rtl/thc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package thc_pkg;

    localparam int TEMP_W        = 11;  // sample and scale registers
    localparam int CH_W          = 8;   // color channel drive level
    localparam int CFG_IDX_W     = 2;
    localparam int FRAC_BITS_DEF = 8;
    localparam int SEGMENTS      = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 2'd1;

    localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST = 11'sd200;
    localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 11'sd350;

    localparam logic [CH_W-1:0] FAULT_BLUE = 8'd25;
    localparam logic [CH_W-1:0] CH_FULL    = 8'd255;

    typedef logic signed [TEMP_W-1:0] t_temp;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // black, blue, cyan, green, yellow, red, white
    localparam t_rgb PALETTE [0:SEGMENTS] = '{
        '{8'd0,   8'd0,   8'd0  },
        '{8'd0,   8'd0,   8'd255},
        '{8'd0,   8'd255, 8'd255},
        '{8'd0,   8'd255, 8'd0  },
        '{8'd255, 8'd255, 8'd0  },
        '{8'd255, 8'd0,   8'd0  },
        '{8'd255, 8'd255, 8'd255}
    };

endpackage

`default_nettype wire

// ----- hw/rtl/temperature_heatmap_color_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake           Payload
// -------   ---  ------------------  ------------------------------------------
// sample    in   i_valid / o_stall   i_temperature[10:0] signed, i_sample_ok
// color     out  o_valid / i_stall   o_red[7:0], o_green[7:0], o_blue[7:0]
// config    in   i_cfg_we            i_cfg_idx[1:0], i_cfg_data[10:0]
//
// One word accepted per cycle while o_stall is low. Stages in order: input
// register, clamp/offset stage, FRAC_BITS+3 restoring divider stages (one
// quotient bit each), and the output register with the blend in front of it.
// Synchronous active-low reset clears all valid bits and loads the scale
// registers with 200 / 350. A full stage holds only while the next one is
// blocked, so bubbles squeeze out and a stalled output lets upstream fill.

module temperature_heatmap_color_unit #(
    parameter int FRAC_BITS = thc_pkg::FRAC_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // sample in
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire  signed [thc_pkg::TEMP_W-1:0]  i_temperature,
    input  wire                                i_sample_ok,
    // color out
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic        [thc_pkg::CH_W-1:0]    o_red,
    output logic        [thc_pkg::CH_W-1:0]    o_green,
    output logic        [thc_pkg::CH_W-1:0]    o_blue,
    // config writes
    input  wire                                i_cfg_we,
    input  wire         [thc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire         [thc_pkg::TEMP_W-1:0]  i_cfg_data
);
    import thc_pkg::*;

    // quotient covers 0 .. 6*2^FRAC_BITS
    localparam int QW  = FRAC_BITS + 3;
    // stage 0 input, stage 1 prep, stages 2..QW+1 divider, last is output
    localparam int NST = QW + 3;
    localparam int RW  = TEMP_W;      // divisor and remainder width

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // ---------------- scale registers ----------------
    t_temp r_min_temp;
    t_temp r_max_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_temp <= MIN_TEMP_RST;
            r_max_temp <= MAX_TEMP_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MIN_TEMP) r_min_temp <= t_temp'(i_cfg_data);
            if (i_cfg_idx == CFG_MAX_TEMP) r_max_temp <= t_temp'(i_cfg_data);
        end
    end

    // span must only change while the pipe is empty (the user's duty, not enforced here), so all stages share it
    logic signed [TEMP_W:0] span;
    logic                   span_bad;
    logic [RW-1:0]          divisor;

    assign span     = {r_max_temp[TEMP_W-1], r_max_temp}
                    - {r_min_temp[TEMP_W-1], r_min_temp};
    assign span_bad = span[TEMP_W] || (span == '0);
    assign divisor  = span[RW-1:0];

    // ---------------- flow control ----------------
    logic [NST-1:0] r_vld;
    logic [NST-1:0] adv;

    always_comb begin
        adv[NST-1] = !r_vld[NST-1] || !i_stall;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ---------------- stage 0: input register ----------------
    t_temp r_temp;
    logic  r_ok;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_temp <= i_temperature;
            r_ok   <= i_sample_ok;
        end
    end

    // ---------------- stage 1: clamp, offset, times six ----------------
    // divider arrays: index 0 is the prep stage, index k the k-th quotient bit
    logic [RW-1:0] r_rem   [0:QW];
    logic [QW-1:0] r_quo   [0:QW];
    logic [2:0]    r_lo    [0:QW];
    logic          r_fault [0:QW];
    logic          r_black [0:QW];

    t_temp         temp_clamp;
    logic [RW-1:0] offs;
    logic [RW+2:0] offs6;

    always_comb begin
        if (r_temp < r_min_temp) begin
            temp_clamp = r_min_temp;
        end else if (r_temp > r_max_temp) begin
            temp_clamp = r_max_temp;
        end else begin
            temp_clamp = r_temp;
        end
        // 0 <= c <= span <= 2047, so the wrapped 11-bit difference is exact
        offs  = RW'(temp_clamp - r_min_temp);
        // 6c = 4c + 2c, at most 12282
        offs6 = {1'b0, offs, 2'b00} + {2'b00, offs, 1'b0};
    end

    // (6c << F) >> QW is below the divisor; low three bits of 6c feed in next
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_rem[0]   <= offs6[RW+2:3];
            r_lo[0]    <= offs6[2:0];
            r_quo[0]   <= '0;
            r_fault[0] <= !r_ok;
            r_black[0] <= span_bad;
        end
    end

    // ---------------- restoring divider, one bit per stage ----------------
    for (genvar g = 1; g <= QW; g++) begin : g_div
        logic [RW:0]   trial;
        logic          q_bit;
        logic [RW:0]   diff;
        logic [RW-1:0] n_rem;

        assign trial = {r_rem[g-1], r_lo[g-1][2]};
        assign q_bit = (trial >= {1'b0, divisor});
        assign diff  = trial - {1'b0, divisor};
        assign n_rem = q_bit ? diff[RW-1:0] : trial[RW-1:0];

        always_ff @(posedge i_clk) begin
            if (adv[g+1]) begin
                r_rem[g]   <= n_rem;
                r_quo[g]   <= {r_quo[g-1][QW-2:0], q_bit};
                r_lo[g]    <= {r_lo[g-1][1:0], 1'b0};
                r_fault[g] <= r_fault[g-1];
                r_black[g] <= r_black[g-1];
            end
        end
    end

    // ---------------- blend and output register ----------------
    function automatic logic [CH_W-1:0] blend(
        input logic [CH_W-1:0]      a,
        input logic [CH_W-1:0]      b,
        input logic [FRAC_BITS-1:0] f
    );
        logic [FRAC_BITS:0]        w;
        logic [FRAC_BITS+CH_W:0]   pa;
        logic [FRAC_BITS+CH_W:0]   pb;
        logic [FRAC_BITS+CH_W:0]   sum;
        w   = ONE - {1'b0, f};
        pa  = {{(FRAC_BITS+1){1'b0}}, a} * {{CH_W{1'b0}}, w};
        pb  = {{(FRAC_BITS+1){1'b0}}, b} * {{CH_W{1'b0}}, 1'b0, f};
        sum = pa + pb;
        return sum[FRAC_BITS+CH_W-1:FRAC_BITS];
    endfunction

    logic [2:0]           seg;
    logic [FRAC_BITS-1:0] frac;
    logic [2:0]           seg_nx;
    t_rgb                 col_a;
    t_rgb                 col_b;
    t_rgb                 n_col;

    assign seg    = r_quo[QW][QW-1:FRAC_BITS];
    assign frac   = r_quo[QW][FRAC_BITS-1:0];
    assign seg_nx = seg + 3'd1;

    always_comb begin
        // table reads only matter below the top segment
        col_a = PALETTE[0];
        col_b = PALETTE[0];
        if (seg < 3'(SEGMENTS)) begin
            col_a = PALETTE[seg];
            col_b = PALETTE[seg_nx];
        end
        priority if (r_fault[QW]) begin
            n_col = '{8'd0, 8'd0, FAULT_BLUE};
        end else if (r_black[QW]) begin
            n_col = '0;
        end else if (seg >= 3'(SEGMENTS)) begin
            n_col = '{CH_FULL, CH_FULL, CH_FULL};
        end else begin
            n_col.red   = blend(col_a.red,   col_b.red,   frac);
            n_col.green = blend(col_a.green, col_b.green, frac);
            n_col.blue  = blend(col_a.blue,  col_b.blue,  frac);
        end
    end

    t_rgb r_col;

    always_ff @(posedge i_clk) begin
        if (adv[NST-1]) begin
            r_col <= n_col;
        end
    end

    assign o_red   = r_col.red;
    assign o_green = r_col.green;
    assign o_blue  = r_col.blue;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import thc_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int ONE         = 1 << FRAC;
    // pipeline is FRAC+6 deep; leave some slack before touching the scale regs
    localparam int DRAIN_GAP   = FRAC + 14;
    localparam int QUIET_LIMIT = 4000;  // cycles with no handshake on either side
    localparam int LONG_HOLD   = 120;   // forced back-pressure stretch, cycles

    // indexes that map to no register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct {
        t_temp temp;
        logic  ok;
    } t_sample;

    // ---------------------------------------------------------------------
    // clock, reset, DUT ports
    // ---------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic                 i_valid       = 1'b0;
    logic                 o_stall;
    t_temp                i_temperature = '0;
    logic                 i_sample_ok   = 1'b0;
    logic                 o_valid;
    logic                 i_stall       = 1'b0;
    logic [CH_W-1:0]      o_red;
    logic [CH_W-1:0]      o_green;
    logic [CH_W-1:0]      o_blue;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = CFG_MIN_TEMP;
    logic [TEMP_W-1:0]    i_cfg_data    = '0;

    temperature_heatmap_color_unit #(
        .FRAC_BITS (FRAC)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_temperature (i_temperature),
        .i_sample_ok   (i_sample_ok),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // ---------------------------------------------------------------------
    // shared state
    // ---------------------------------------------------------------------
    t_sample pending [$];        // sample words not yet put on the bus
    t_rgb    color_q [$];        // colors owed by the DUT, oldest first
    t_temp   scale_lo;           // mirror of min_temp
    t_temp   scale_hi;           // mirror of max_temp
    bit      word_taken = 1'b0;  // sample word accepted at the last rising edge

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_asks     = 0;       // bumped by the sequencer to request a long hold
    int hold_seen     = 0;
    int hold_left     = 0;

    int n_pushed   = 0;
    int n_samples  = 0;
    int n_colors   = 0;
    int n_errors   = 0;
    int n_settings = 0;
    int quiet      = 0;

    // ---------------------------------------------------------------------
    // color prediction
    // ---------------------------------------------------------------------
    // black, blue, cyan, green, yellow, red, white
    function automatic t_rgb heat_stop(int idx);
        case (idx)
            0:       return '{8'd0,   8'd0,   8'd0};
            1:       return '{8'd0,   8'd0,   8'd255};
            2:       return '{8'd0,   8'd255, 8'd255};
            3:       return '{8'd0,   8'd255, 8'd0};
            4:       return '{8'd255, 8'd255, 8'd0};
            5:       return '{8'd255, 8'd0,   8'd0};
            default: return '{8'd255, 8'd255, 8'd255};
        endcase
    endfunction

    // weighted blend, truncated
    function automatic logic [CH_W-1:0] mix_level(int a, int b, int frac);
        return CH_W'((a * (ONE - frac) + b * frac) >> FRAC);
    endfunction

    function automatic t_rgb color_for(t_temp temp, logic ok);
        int      lo;
        int      hi;
        int      t;
        int      span;
        int      seg;
        int      frac;
        longint  pos;
        t_rgb    a;
        t_rgb    b;
        t_rgb    col;
        lo = scale_lo;
        hi = scale_hi;
        t  = temp;
        col = '0;
        // sensor fault wins over everything else
        if (!ok) begin
            col.blue = FAULT_BLUE;
            return col;
        end
        span = hi - lo;
        if (span <= 0) begin
            return col;
        end
        if (t < lo) t = lo;
        if (t > hi) t = hi;
        // position across six segments, FRAC fraction bits
        pos  = (longint'(t - lo) * SEGMENTS * ONE) / span;
        seg  = int'(pos >> FRAC);
        frac = int'(pos % ONE);
        if (seg >= SEGMENTS) begin
            return '{CH_FULL, CH_FULL, CH_FULL};
        end
        a = heat_stop(seg);
        b = heat_stop(seg + 1);
        col.red   = mix_level(a.red,   b.red,   frac);
        col.green = mix_level(a.green, b.green, frac);
        col.blue  = mix_level(a.blue,  b.blue,  frac);
        return col;
    endfunction

    // ---------------------------------------------------------------------
    // driver: puts sample words on the bus at the falling edge.
    // A word stays put until it is taken; the idle roll only happens
    // once the bus is free, so valid never looks at stall.
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin : feed
        t_sample nxt;
        if (!i_valid || word_taken) begin
            if (i_rst_n && pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending.pop_front();
                i_temperature <= nxt.temp;
                i_sample_ok   <= nxt.ok;
                i_valid       <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure: random, or a long forced hold on request
    always @(negedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------------
    // monitor: everything sampled at the rising edge. Output check runs
    // before the new expectation is queued, so a word taken this edge can
    // never be matched against itself.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_rgb got;
        t_rgb want;
        if (!i_rst_n) begin
            scale_lo   = MIN_TEMP_RST;
            scale_hi   = MAX_TEMP_RST;
            word_taken = 1'b0;
            quiet      = 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_red, o_green, o_blue};
                n_colors++;
                if (color_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: color word with nothing outstanding: r=%0d g=%0d b=%0d",
                                 $realtime, got.red, got.green, got.blue);
                end else begin
                    want = color_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("%0t: color #%0d exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                     $realtime, n_colors, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end

            word_taken = i_valid && !o_stall;
            if (word_taken) begin
                color_q.push_back(color_for(i_temperature, i_sample_ok));
                n_samples++;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_TEMP: scale_lo = i_cfg_data;
                    CFG_MAX_TEMP: scale_hi = i_cfg_data;
                    default: ;  // unmapped index, dropped
                endcase
            end

            // watchdog
            if (word_taken || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d colors outstanding",
                         $realtime, QUIET_LIMIT, color_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    task automatic add_sample(int temp, logic ok);
        t_sample s;
        s.temp = t_temp'(temp);
        s.ok   = ok;
        pending.push_back(s);
        n_pushed++;
    endtask

    // mostly around the configured scale, some anywhere in the 11-bit range
    task automatic add_random(int count, int lo, int hi);
        int a;
        int b;
        int t;
        a = ((lo < hi) ? lo : hi) - 40;
        b = ((lo < hi) ? hi : lo) + 40;
        if (a < -1024) a = -1024;
        if (b > 1023)  b = 1023;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 20)
                t = int'($urandom_range(2047)) - 1024;
            else
                t = a + int'($urandom_range(b - a));
            add_sample(t, $urandom_range(99) >= 8);
        end
    endtask

    // every word taken, every color back, then let the pipe go quiet
    task automatic wait_idle();
        while (n_samples != n_pushed || color_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    // called at a falling edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = TEMP_W'(val);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic run_phase(int lo, int hi, int send_pct, int stl_pct, int count);
        wait_idle();
        write_reg(CFG_MIN_TEMP, lo);
        write_reg(CFG_MAX_TEMP, hi);
        n_settings++;
        @(posedge i_clk);
        send_idle_pct = send_pct;
        stall_pct     = stl_pct;
        add_random(count, lo, hi);
    endtask

    initial begin : sequencer
        int lo;
        int hi;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed pass on the reset scale 20.0 .. 35.0
        n_settings = 1;
        add_sample(-1024, 1'b1);  // most negative field value, clamps low
        add_sample(1023, 1'b1);   // most positive field value, clamps high
        add_sample(-400, 1'b1);
        add_sample(800, 1'b1);
        add_sample(200, 1'b1);    // bottom of scale, black
        add_sample(350, 1'b1);    // top of scale, white
        add_sample(349, 1'b1);
        add_sample(201, 1'b1);
        add_sample(225, 1'b1);    // segment boundaries
        add_sample(250, 1'b1);
        add_sample(275, 1'b1);
        add_sample(300, 1'b1);
        add_sample(325, 1'b1);
        add_sample(262, 1'b1);
        add_sample(0, 1'b1);
        add_sample(275, 1'b0);    // sensor fault, in range
        add_sample(-1024, 1'b0);
        add_sample(1023, 1'b0);
        add_sample(0, 1'b0);

        run_phase(-400, 800, 0, 0, 110);      // widest nominal scale, no idling
        run_phase(200, 350, 80, 0, 90);       // sender mostly idle
        run_phase(100, 101, 0, 80, 80);       // span of one tenth
        run_phase(-1024, 1023, 33, 33, 100);  // whole field range

        // writes to unmapped indexes must leave the scale alone
        wait_idle();
        write_reg(CFG_SPARE_2, -1);
        write_reg(CFG_SPARE_3, 0);
        add_random(40, -1024, 1023);

        run_phase(300, 300, 0, 0, 30);        // zero span, black
        run_phase(800, -400, 80, 80, 30);     // inverted scale, black

        // long receiver hold while the sender keeps pushing: pipe fills
        // and the input side has to stall
        run_phase(-50, 50, 0, 0, 120);
        @(posedge i_clk);
        hold_asks++;

        for (int k = 0; k < 3; k++) begin
            lo = int'($urandom_range(1200)) - 400;
            hi = int'($urandom_range(1200)) - 400;
            if (lo > hi) begin
                lo = lo ^ hi;
                hi = lo ^ hi;
                lo = lo ^ hi;
            end
            run_phase(lo, hi, (k == 1) ? 80 : 33, (k == 2) ? 80 : 33, 40);
        end

        wait_idle();
        $display("%0d sample words over %0d scale settings, %0d colors checked, %0d mismatches",
                 n_samples, n_settings, n_colors, n_errors);
        $display("covered faults, clamping both ends, zero/negative span and unmapped writes");
        if (n_errors == 0 && color_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
